[rtl/core/lir_pkg.sv]
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  // Sample and rate formats
  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 18;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [RATE_W-1:0]          rate_t;

  // Rate registers after reset
  localparam rate_t SRC_RESET = rate_t'(48000);
  localparam rate_t TGT_RESET = rate_t'(16000);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SOURCE_RATE = 1'b0;
  localparam cfg_idx_t REG_TARGET_RATE = 1'b1;

  // Most results one input transaction may cause
  localparam int RESULT_LIMIT = 64;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);
  typedef logic [CNT_W-1:0] res_cnt_t;

endpackage

[rtl/core/lir_in_if.sv]
// ----------------------------------------------------------------------------
// lir_in_if
// Input sample channel: valid/ready handshake with sample and end marker.
// ----------------------------------------------------------------------------
interface lir_in_if import lir_pkg::*; ();

  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    end_of_stream;

  modport source (output valid, sample_in, end_of_stream, input ready);
  modport sink   (input valid, sample_in, end_of_stream, output ready);

endinterface

[rtl/core/lir_out_if.sv]
// ----------------------------------------------------------------------------
// lir_out_if
// Result channel: valid/ready handshake with sample and end-of-run flag.
// ----------------------------------------------------------------------------
interface lir_out_if import lir_pkg::*; ();

  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    last_of_run;

  modport source (output valid, sample_out, last_of_run, input ready);
  modport sink   (input valid, sample_out, last_of_run, output ready);

endinterface

[rtl/core/linear_interp_resampler.sv]
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Streaming linear interpolation sample-rate converter for mono Q1.15 audio.
//
// Flow: one input transaction at a time; a new sample is taken only in IDLE,
//   once every result of the last one has been handed on. Each interpolated
//   result takes a division, a rounding and a sum step; output stalls hold it.
// Latency: a result enters the output register once the following result or
//   the end of the run is known, so the last result of a run appears at DONE.
// Reset: synchronous active-low; rates return to 48000/16000, clip state clears.
// ----------------------------------------------------------------------------
module linear_interp_resampler import lir_pkg::*; #(
  parameter int MAX_UPSAMPLE = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  lir_in_if.sink        in_ch,
  lir_out_if.source     out_ch,
  input  logic          cfg_we,
  input  cfg_idx_t      cfg_index,
  input  rate_t         cfg_data
);

  // Derived widths
  localparam int MUL_W = RATE_W + $clog2(MAX_UPSAMPLE + 1);
  localparam int PH_W  = RATE_W + 2;
  localparam int DIF_W = SAMPLE_W + 1;
  localparam int ACC_W = FRAC_BITS + SAMPLE_W + 2;
  localparam int BC_W  = $clog2(FRAC_BITS + 1);

  localparam logic [ACC_W-1:0] RND_BIAS =
    {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_RND   = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_FLUSH = 4'd6;
  localparam logic [3:0] S_POST  = 4'd7;
  localparam logic [3:0] S_TAIL  = 4'd8;
  localparam logic [3:0] S_PUT   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]              state_r, ret_r;
  rate_t                   src_r, tgt_r, from_r, to_r;
  sample_t                 cur_r, prev_r, pend_r, put_r, held_r;
  logic                    eos_r, have_r, pend_v_r, held_v_r;
  logic [PH_W-1:0]         p_r;
  res_cnt_t                cnt_r;
  logic [RATE_W-1:0]       rem_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [DIF_W-1:0] diff_r;
  logic [BC_W-1:0]         bit_r;
  logic                    out_valid_r, out_last_r;
  sample_t                 out_sample_r;

  rate_t                   from_c, tgt_c, to_c;
  logic [MUL_W-1:0]        cap_c;
  logic [RATE_W:0]         r2_c;
  logic                    ge_c, rb_c, out_free_c, out_load_c;
  logic signed [ACC_W-1:0] diff_ext_c, shifted_c;
  sample_t                 interp_c;

  // Effective rates: zero reads as one, target capped by the upsample limit
  always_comb begin
    from_c = (src_r == '0) ? rate_t'(1) : src_r;
    tgt_c  = (tgt_r == '0) ? rate_t'(1) : tgt_r;
    cap_c  = MUL_W'(from_c) * MUL_W'(MAX_UPSAMPLE);
    to_c   = (MUL_W'(tgt_c) > cap_c) ? cap_c[RATE_W-1:0] : tgt_c;
  end

  // One restoring-division step; the quotient bit feeds the Horner multiply
  assign r2_c       = {rem_r, 1'b0};
  assign ge_c       = r2_c >= {1'b0, to_r};
  assign diff_ext_c = ACC_W'(diff_r);
  // Round the fraction up when the remainder reaches half the divisor
  assign rb_c       = ({1'b0, rem_r} + {1'b0, to_r >> 1}) >= {1'b0, to_r};
  assign shifted_c  = acc_r >>> FRAC_BITS;
  assign interp_c   = prev_r + sample_t'(shifted_c[SAMPLE_W-1:0]);

  assign out_free_c = !out_valid_r || out_ch.ready;

  // Move the held result into the output register
  assign out_load_c = held_v_r && out_free_c &&
                      (((state_r == S_PUT) && (cnt_r != res_cnt_t'(RESULT_LIMIT))) ||
                       (state_r == S_DONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_c) begin
      out_valid_r  <= 1'b1;
      out_sample_r <= held_r;
      out_last_r   <= (state_r == S_DONE);
    end else if (out_ch.ready) begin
      // Drop the output transaction once taken
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      src_r       <= SRC_RESET;
      tgt_r       <= TGT_RESET;
      prev_r      <= '0;
      have_r      <= 1'b0;
      p_r         <= '0;
      pend_v_r    <= 1'b0;
      held_v_r    <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SOURCE_RATE: src_r <= cfg_data;
          REG_TARGET_RATE: tgt_r <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur_r   <= in_ch.sample_in;
            eos_r   <= in_ch.end_of_stream;
            state_r <= S_LOAD;
          end
        end

        S_LOAD: begin
          from_r <= from_c;
          to_r   <= to_c;
          cnt_r  <= '0;
          if (from_c == to_c) begin
            // Equal rates: pass the sample through
            prev_r   <= cur_r;
            have_r   <= 1'b1;
            p_r      <= PH_W'(from_c);
            pend_v_r <= 1'b0;
            put_r    <= cur_r;
            ret_r    <= S_DONE;
            state_r  <= S_PUT;
          end else if (have_r) begin
            state_r <= S_CHK;
          end else begin
            prev_r  <= cur_r;
            have_r  <= 1'b1;
            state_r <= S_POST;
          end
        end

        S_CHK: begin
          if (p_r < PH_W'(to_r)) begin
            rem_r   <= p_r[RATE_W-1:0];
            acc_r   <= '0;
            diff_r  <= DIF_W'(cur_r) - DIF_W'(prev_r);
            bit_r   <= BC_W'(FRAC_BITS);
            state_r <= S_DIV;
          end else begin
            state_r <= S_FLUSH;
          end
        end

        S_DIV: begin
          rem_r <= ge_c ? RATE_W'(r2_c - {1'b0, to_r}) : r2_c[RATE_W-1:0];
          acc_r <= (acc_r <<< 1) + (ge_c ? diff_ext_c : '0);
          bit_r <= bit_r - 1'b1;
          if (bit_r == BC_W'(1)) begin
            state_r <= S_RND;
          end
        end

        S_RND: begin
          acc_r   <= acc_r + (rb_c ? diff_ext_c : '0) + $signed(RND_BIAS);
          state_r <= S_SUM;
        end

        S_SUM: begin
          // Release the older pending result, hold the new one back
          pend_r   <= interp_c;
          pend_v_r <= 1'b1;
          p_r      <= p_r + PH_W'(from_r);
          if (pend_v_r) begin
            put_r   <= pend_r;
            ret_r   <= S_CHK;
            state_r <= S_PUT;
          end else begin
            state_r <= S_CHK;
          end
        end

        S_FLUSH: begin
          p_r    <= p_r - PH_W'(to_r);
          prev_r <= cur_r;
          have_r <= 1'b1;
          if (pend_v_r && (p_r <= PH_W'({to_r, 1'b0}))) begin
            pend_v_r <= 1'b0;
            put_r    <= pend_r;
            ret_r    <= S_POST;
            state_r  <= S_PUT;
          end else begin
            state_r <= S_POST;
          end
        end

        S_POST: begin
          if (eos_r) begin
            pend_v_r <= 1'b0;
            state_r  <= S_TAIL;
          end else begin
            state_r <= S_DONE;
          end
        end

        S_TAIL: begin
          // Trailing outputs hold the final sample
          if ((p_r + PH_W'(from_r)) <= PH_W'(to_r)) begin
            p_r     <= p_r + PH_W'(from_r);
            put_r   <= cur_r;
            ret_r   <= S_TAIL;
            state_r <= S_PUT;
          end else begin
            state_r <= S_DONE;
          end
        end

        S_PUT: begin
          // One-deep hold so the last result of a run can be flagged
          if (cnt_r == res_cnt_t'(RESULT_LIMIT)) begin
            state_r <= ret_r;
          end else if (!held_v_r || out_free_c) begin
            held_r   <= put_r;
            held_v_r <= 1'b1;
            cnt_r    <= cnt_r + 1'b1;
            state_r  <= ret_r;
          end
        end

        S_DONE: begin
          if (!held_v_r || out_free_c) begin
            held_v_r <= 1'b0;
            // End of clip: start the next one fresh
            if (eos_r) begin
              prev_r   <= '0;
              have_r   <= 1'b0;
              p_r      <= '0;
              pend_r   <= '0;
              pend_v_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Channel outputs
  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_out  = out_sample_r;
  assign out_ch.last_of_run = out_last_r;

  // Checks
  a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !held_v_r)
    else $error("held result left over at end of run");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= res_cnt_t'(RESULT_LIMIT))
    else $error("result count beyond limit");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < to_r))
    else $error("division remainder out of range");

  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    p_r[PH_W-1] == 1'b0)
    else $error("phase remainder overflow");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear interpolation resampler. A directed
// stimulus list covers sample extremes, pass-through, zero and saturated
// rates, the result cap and rate changes inside a clip. Random clips at
// random rates follow. Every accepted input runs through a cycle-free
// resampling predictor, and each output transaction is compared against
// the oldest predicted sample. Both channels see random idle and stall
// patterns.
// ----------------------------------------------------------------------------
module tb import lir_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_UPSAMPLE  = 32;
  localparam int FRAC_BITS     = 16;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS  = 145;
  localparam int N_DIRECTED    = 35;

  typedef struct {
    sample_t smp;
    logic    last;
  } out_sample_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_PASS, ROW_CFG} row_kind_t;

  // A pass row's sample must come back unchanged as a single result.
  typedef struct packed {
    row_kind_t kind;
    cfg_idx_t  idx;
    rate_t     rate;
    sample_t   smp;
    logic      eos;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  rate_t cfg_data;

  lir_in_if  in_ch ();
  lir_out_if out_ch ();

  linear_interp_resampler #(
    .MAX_UPSAMPLE (MAX_UPSAMPLE),
    .FRAC_BITS    (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: rates, clip state and the held-back down-conversion output
  rate_t       pr_src;
  rate_t       pr_tgt;
  int          pr_prev;
  bit          pr_have_prev;
  int unsigned pr_phase;
  int          pr_held;
  bit          pr_held_valid;

  out_sample_t step_out [$];
  out_sample_t due_samples [$];
  out_sample_t head;

  int mismatches;
  int items_sent;
  int burst_left;
  int ready_hold;
  int ready_mode;

  int unsigned common_rates [8] = '{8000, 11025, 16000, 22050, 44100, 48000, 96000, 192000};

  row_t directed_rows [N_DIRECTED] = '{
    // Default 3:1 down-conversion, full-scale steps
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh7FFF, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh8000, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sd12345, 1'b1},
    // Equal top rates pass samples through
    '{ROW_CFG, REG_SOURCE_RATE, 18'd192000, 16'sh0000, 1'b0},
    '{ROW_CFG, REG_TARGET_RATE, 18'd192000, 16'sh0000, 1'b0},
    '{ROW_PASS, REG_SOURCE_RATE, 18'd0, 16'sh8000, 1'b0},
    '{ROW_PASS, REG_SOURCE_RATE, 18'd0, 16'sh7FFF, 1'b1},
    // Zero rates act as 1 Hz, still equal
    '{ROW_CFG, REG_SOURCE_RATE, 18'd0, 16'sh0000, 1'b0},
    '{ROW_CFG, REG_TARGET_RATE, 18'd0, 16'sh0000, 1'b0},
    '{ROW_PASS, REG_SOURCE_RATE, 18'd0, 16'sh0001, 1'b0},
    '{ROW_PASS, REG_SOURCE_RATE, 18'd0, 16'shFFFF, 1'b1},
    // Saturated target, first-sample hold, result cap, single-sample clip
    '{ROW_CFG, REG_SOURCE_RATE, 18'd1, 16'sh0000, 1'b0},
    '{ROW_CFG, REG_TARGET_RATE, 18'h3FFFF, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh8000, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh7FFF, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sh0000, 1'b1},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sd5, 1'b1},
    // Small up-conversion, then rate changes inside the clip
    '{ROW_CFG, REG_SOURCE_RATE, 18'd3, 16'sh0000, 1'b0},
    '{ROW_CFG, REG_TARGET_RATE, 18'd7, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sd1000, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, -16'sd1000, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sd2000, 1'b0},
    '{ROW_CFG, REG_TARGET_RATE, 18'd3, 16'sh0000, 1'b0},
    '{ROW_PASS, REG_SOURCE_RATE, 18'd0, 16'sd500, 1'b0},
    '{ROW_CFG, REG_TARGET_RATE, 18'd2, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sd700, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, -16'sd700, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sd900, 1'b1},
    // Non-integer down-conversion with trailing drop
    '{ROW_CFG, REG_SOURCE_RATE, 18'd7, 16'sh0000, 1'b0},
    '{ROW_CFG, REG_TARGET_RATE, 18'd5, 16'sh0000, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sd300, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sd200, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sd100, 1'b0},
    '{ROW_SAMPLE, REG_SOURCE_RATE, 18'd0, 16'sd0, 1'b1}
  };

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run limit
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Interpolate between a and b at phase ph of 1/to, rounded to Q1.15
  function automatic int blend_point(int a, int b, int unsigned ph, int unsigned to);
    longint frac;
    longint prod;
    frac = ((longint'(ph) <<< FRAC_BITS) + longint'(to / 2)) / longint'(to);
    prod = longint'(b - a) * frac;
    return a + int'((prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
  endfunction

  function automatic void emit_result(int v);
    out_sample_t r;
    r.smp  = sample_t'(v);
    r.last = 1'b0;
    if (step_out.size() < RESULT_LIMIT) step_out.push_back(r);
  endfunction

  // Advance the predictor by one input sample; results land in step_out
  function automatic void resample_step(sample_t smp, logic eos);
    int          cur;
    int          v;
    int unsigned from;
    int unsigned to;
    int unsigned p;
    cur = int'(smp);
    from = (pr_src == '0) ? 1 : int'(pr_src);
    to   = (pr_tgt == '0) ? 1 : int'(pr_tgt);
    if (to > MAX_UPSAMPLE * from) to = MAX_UPSAMPLE * from;
    step_out.delete();

    if (from == to) begin
      emit_result(cur);
      pr_prev       = cur;
      pr_have_prev  = 1'b1;
      pr_phase      = from;
      pr_held_valid = 1'b0;
    end else begin
      p = pr_phase;
      if (pr_have_prev) begin
        // Each output is held until the next one proves the clip covers it
        while (p < to) begin
          v = blend_point(pr_prev, cur, p, to);
          if (pr_held_valid) emit_result(pr_held);
          pr_held       = v;
          pr_held_valid = 1'b1;
          p += from;
        end
        if (pr_held_valid && p <= 2 * to) begin
          emit_result(pr_held);
          pr_held_valid = 1'b0;
        end
        p -= to;
      end
      pr_have_prev = 1'b1;
      pr_prev      = cur;
      // Drop an uncovered held output, pad the tail with the final value
      if (eos) begin
        pr_held_valid = 1'b0;
        while (p + from <= to) begin
          emit_result(cur);
          p += from;
        end
      end
      pr_phase = p & 32'h00FF_FFFF;
    end

    if (eos) begin
      pr_prev       = 0;
      pr_have_prev  = 1'b0;
      pr_phase      = 0;
      pr_held       = 0;
      pr_held_valid = 1'b0;
    end

    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // Send one sample in bursts with random gaps, then predict its results
  task automatic send_item(input sample_t smp, input logic eos, input bit typed);
    int gap;
    out_sample_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.sample_in     <= smp;
    in_ch.end_of_stream <= eos;
    do @(posedge clk); while (!in_ch.ready);
    resample_step(smp, eos);
    if (typed) begin
      r.smp  = smp;
      r.last = 1'b1;
      due_samples.push_back(r);
    end else begin
      foreach (step_out[i]) due_samples.push_back(step_out[i]);
    end
    items_sent++;
  endtask

  // Hold input idle until every result is out and the block has gone quiet
  task automatic settle_block();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input rate_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      REG_SOURCE_RATE: pr_src = val;
      REG_TARGET_RATE: pr_tgt = val;
      default: ;
    endcase
  endtask

  task automatic pick_rates();
    int unsigned src;
    int unsigned tgt;
    case ($urandom_range(0, 4))
      0: begin
        src = common_rates[$urandom_range(0, 7)];
        tgt = common_rates[$urandom_range(0, 7)];
      end
      1: begin
        src = $urandom_range(1, 8);
        tgt = $urandom_range(1, 8);
      end
      2: begin
        src = $urandom_range(0, 18'h3FFFF);
        tgt = $urandom_range(0, 18'h3FFFF);
      end
      3: begin
        src = common_rates[$urandom_range(0, 7)];
        tgt = src;
      end
      default: begin
        src = $urandom_range(1, 8);
        tgt = src * MAX_UPSAMPLE + $urandom_range(0, 300);
      end
    endcase
    settle_block();
    write_reg(REG_SOURCE_RATE, rate_t'(src));
    write_reg(REG_TARGET_RATE, rate_t'(tgt));
  endtask

  // Result stall pattern: modes held for random stretches
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_hold = $urandom_range(16, 96);
    end else begin
      ready_hold--;
    end
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 5) == 0);
      default: out_ch.ready <= ready_hold[2];
    endcase
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected output sample %0d last %0b",
                                  out_ch.sample_out, out_ch.last_of_run));
      end else begin
        head = due_samples.pop_front();
        if (out_ch.sample_out !== head.smp)
          report_mismatch($sformatf("sample_out %0d, want %0d",
                                    out_ch.sample_out, head.smp));
        if (out_ch.last_of_run !== head.last)
          report_mismatch($sformatf("last_of_run %0b, want %0b (sample %0d)",
                                    out_ch.last_of_run, head.last, head.smp));
      end
    end
  end

  // Main sequence
  initial begin
    int          clip_len;
    int unsigned mid_tgt;
    sample_t     smp;
    logic        eos;
    bit          cfg_pending;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_SOURCE_RATE;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.sample_in     = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready        = 1'b0;
    mismatches          = 0;
    items_sent          = 0;
    burst_left          = 0;
    ready_hold          = 0;
    ready_mode          = 0;
    cfg_pending         = 1'b0;

    pr_src        = SRC_RESET;
    pr_tgt        = TGT_RESET;
    pr_prev       = 0;
    pr_have_prev  = 1'b0;
    pr_phase      = 0;
    pr_held       = 0;
    pr_held_valid = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed list
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          if (!cfg_pending) settle_block();
          cfg_pending = 1'b1;
          write_reg(directed_rows[i].idx, directed_rows[i].rate);
        end
        ROW_PASS: begin
          cfg_pending = 1'b0;
          send_item(directed_rows[i].smp, directed_rows[i].eos, 1'b1);
        end
        default: begin
          cfg_pending = 1'b0;
          send_item(directed_rows[i].smp, directed_rows[i].eos, 1'b0);
        end
      endcase
    end

    // Random clips at random rates
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) pick_rates();
      clip_len = $urandom_range(1, 12);
      for (int i = 0; i < clip_len; i++) begin
        // Occasionally retune the target inside a clip
        if (i > 0 && i == clip_len / 2 && $urandom_range(0, 5) == 0) begin
          mid_tgt = $urandom_range(1, 2 * ((pr_src == '0) ? 1 : int'(pr_src)) + 1);
          if (mid_tgt > 18'h3FFFF) mid_tgt = 18'h3FFFF;
          settle_block();
          write_reg(REG_TARGET_RATE, rate_t'(mid_tgt));
        end
        if ($urandom_range(0, 7) == 0)
          smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else
          smp = sample_t'($urandom);
        eos = (i == clip_len - 1) && ($urandom_range(0, 7) != 0);
        send_item(smp, eos, 1'b0);
      end
    end

    // Drain and finish
    @(negedge clk) in_ch.valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
